// ===== rtl/rrfcfs_pkg.sv =====
// Shared types, codes and constants of the two-level round-robin / FCFS scheduler.
// Used by rrfcfs_ctrl, rrfcfs_dpath and two_level_rr_fcfs_scheduler; no dependencies.
`default_nettype none
package rrfcfs_pkg;

    localparam int PROCESS_SLOTS_DEF = 32;
    localparam logic [7:0] QUANTUM_RESET = 8'd4;
    localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_ARRIVAL = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_DRAIN   = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_DROP = 1'b1;
    localparam logic LEVEL_RR    = 1'b0;
    localparam logic LEVEL_FCFS  = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] req_id;
        logic [15:0] req_burst;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [15:0] job_id;
        logic        queue_level;
        logic [15:0] burst_time;
        logic [31:0] finish_time;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] burst;
        logic [15:0] remain;
    } t_job;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic arrive;
        logic drop;
        logic slice;
        logic to_pend;
        logic fcfs_run;
        logic flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rr_empty;
        logic fcfs_empty;
        logic full;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/rrfcfs_ctrl.sv =====
// Sequencer of the scheduler: decodes each request and steps through slices and drains.
// Depends on rrfcfs_pkg; drives the datapath only through t_cmd and reads t_status.
`default_nettype none
module rrfcfs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [1:0]           i_operation,
    output logic                      o_in_stall,
    input  wire rrfcfs_pkg::t_status  i_status,
    output rrfcfs_pkg::t_cmd          o_cmd
);
    import rrfcfs_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_EXEC_RR = 3'd2;
    localparam logic [2:0] S_EXEC_FC = 3'd3;
    localparam logic [2:0] S_FLUSH   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_drain, n_drain;
    logic       accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_status.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_ARRIVAL: begin
                            if (i_status.full) begin
                                o_cmd.drop = 1'b1;
                            end else begin
                                o_cmd.arrive = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            n_drain = 1'b0;
                            n_state = S_READ;
                        end
                        OP_DRAIN: begin
                            n_drain = 1'b1;
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // The ring heads are read every cycle; this state lets the read data settle.
            S_READ: begin
                if (!i_status.rr_empty) begin
                    n_state = S_EXEC_RR;
                end else if (r_drain && !i_status.fcfs_empty) begin
                    n_state = S_EXEC_FC;
                end else if (r_drain) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC_RR: begin
                if (i_status.out_free) begin
                    o_cmd.slice   = 1'b1;
                    o_cmd.to_pend = r_drain;
                    n_state       = r_drain ? S_READ : S_IDLE;
                end
            end
            S_EXEC_FC: begin
                if (i_status.out_free) begin
                    o_cmd.fcfs_run = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rrfcfs_dpath.sv =====
// Datapath of the scheduler: both job rings, heads and counts, clock, quantum and result registers.
// Depends on rrfcfs_pkg; acts on t_cmd from rrfcfs_ctrl and reports t_status.
`default_nettype none
module rrfcfs_dpath #(
    parameter int PROCESS_SLOTS = rrfcfs_pkg::PROCESS_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [7:0]             i_cfg_wdata,
    input  wire rrfcfs_pkg::t_in_item   i_in_item,
    input  wire rrfcfs_pkg::t_cmd       i_cmd,
    output rrfcfs_pkg::t_status         o_status,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output rrfcfs_pkg::t_out_item       o_out_item
);
    import rrfcfs_pkg::*;

    localparam int IW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int CW = $clog2(PROCESS_SLOTS + 1);
    localparam logic [IW:0] SLOTS_X = (IW + 1)'(PROCESS_SLOTS);
    localparam logic [CW:0] SLOTS_C = (CW + 1)'(PROCESS_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(PROCESS_SLOTS - 1);

    t_job rr_mem   [PROCESS_SLOTS];
    t_job fcfs_mem [PROCESS_SLOTS];

    t_job          r_rr_rd, r_fc_rd;
    logic [IW-1:0] r_rr_head, r_fc_head;
    logic [CW-1:0] r_rr_count, r_fc_count;
    logic [31:0]   r_clock, n_clock;
    logic [7:0]    r_quantum;
    t_out_item     r_out, n_out, r_pend, n_pend;
    logic          r_out_valid, n_out_valid, r_pend_valid, n_pend_valid;

    logic [IW-1:0] rr_tail, fc_tail;
    logic [15:0]   run, remain_left, add_val;
    logic [32:0]   clock_sum;
    logic          finished;
    t_out_item     done_item;
    t_job          new_job;

    function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] head, logic [CW-1:0] cnt);
        logic [IW:0] s;
        s = (IW + 1)'(head) + (IW + 1)'(cnt);
        if (s >= SLOTS_X) begin
            s = s - SLOTS_X;
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] head);
        return (head == LAST_IDX) ? '0 : head + 1'b1;
    endfunction

    assign rr_tail = wrap_add(r_rr_head, r_rr_count);
    assign fc_tail = wrap_add(r_fc_head, r_fc_count);

    assign o_status.rr_empty   = (r_rr_count == '0);
    assign o_status.fcfs_empty = (r_fc_count == '0);
    assign o_status.full       = ((CW + 1)'(r_rr_count) + (CW + 1)'(r_fc_count)) >= SLOTS_C;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A slice runs for the smaller of the remaining time and the quantum.
    assign run         = (r_rr_rd.remain <= {8'd0, r_quantum}) ? r_rr_rd.remain
                                                               : {8'd0, r_quantum};
    assign remain_left = r_rr_rd.remain - run;
    assign finished    = (remain_left == '0);
    assign add_val     = i_cmd.fcfs_run ? r_fc_rd.remain : run;
    assign clock_sum   = {1'b0, r_clock} + {17'd0, add_val};

    assign new_job.id     = r_rr_rd.id;
    assign new_job.burst  = r_rr_rd.burst;
    assign new_job.remain = remain_left;

    always_comb begin
        n_clock = r_clock;
        if (i_cmd.slice || i_cmd.fcfs_run) begin
            n_clock = clock_sum[32] ? CLOCK_MAX : clock_sum[31:0];
        end

        done_item.status      = STATUS_DONE;
        done_item.job_id      = i_cmd.fcfs_run ? r_fc_rd.id : r_rr_rd.id;
        done_item.queue_level = i_cmd.fcfs_run ? LEVEL_FCFS : LEVEL_RR;
        done_item.burst_time  = i_cmd.fcfs_run ? r_fc_rd.burst : r_rr_rd.burst;
        done_item.finish_time = n_clock;
        done_item.last        = 1'b0;

        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;

        if (i_cmd.drop) begin
            n_out.status      = STATUS_DROP;
            n_out.job_id      = i_in_item.req_id;
            n_out.queue_level = LEVEL_RR;
            n_out.burst_time  = i_in_item.req_burst;
            n_out.finish_time = '0;
            n_out.last        = 1'b1;
            n_out_valid       = 1'b1;
        end else if ((i_cmd.slice && finished && !i_cmd.to_pend) ) begin
            n_out       = done_item;
            n_out.last  = 1'b1;
            n_out_valid = 1'b1;
        end else if ((i_cmd.slice && finished) || i_cmd.fcfs_run) begin
            // During a drain the newest completion is held back until it is known
            // whether another one follows, so that only the final one is flagged last.
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out_valid = 1'b1;
            end
            n_pend       = done_item;
            n_pend_valid = 1'b1;
        end else if (i_cmd.flush && r_pend_valid) begin
            n_out        = r_pend;
            n_out.last   = 1'b1;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arrive) begin
            rr_mem[rr_tail] <= '{id: i_in_item.req_id,
                                 burst: i_in_item.req_burst,
                                 remain: i_in_item.req_burst};
        end
        r_rr_rd <= rr_mem[r_rr_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slice && !finished) begin
            fcfs_mem[fc_tail] <= new_job;
        end
        r_fc_rd <= fcfs_mem[r_fc_head];
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
        if (!i_rst_n) begin
            r_rr_head    <= '0;
            r_rr_count   <= '0;
            r_fc_head    <= '0;
            r_fc_count   <= '0;
            r_clock      <= '0;
            r_quantum    <= QUANTUM_RESET;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_clock      <= n_clock;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (i_cmd.arrive) begin
                r_rr_count <= r_rr_count + 1'b1;
            end
            if (i_cmd.slice) begin
                r_rr_head  <= wrap_inc(r_rr_head);
                r_rr_count <= r_rr_count - 1'b1;
                if (!finished) begin
                    r_fc_count <= r_fc_count + 1'b1;
                end
            end
            if (i_cmd.fcfs_run) begin
                r_fc_head  <= wrap_inc(r_fc_head);
                r_fc_count <= r_fc_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/two_level_rr_fcfs_scheduler.sv =====
// Top level of the two-level round-robin / FCFS job scheduler.
// Depends on rrfcfs_pkg, rrfcfs_ctrl and rrfcfs_dpath.
//
// Requests enter on i_in_valid / o_in_stall with a t_in_item payload: an arrival,
// a quantum tick or a drain. Results leave on o_out_valid / i_out_stall with a
// t_out_item payload; the final result of a request carries last.
// The quantum register is written through i_cfg_we / i_cfg_wdata.
// A dropped arrival shows its result on the next cycle; an arrival that fits is written to the round-robin ring.
// A tick reads the round-robin head and, unless that ring is empty, runs one slice;
// a job that the slice finishes shows its result once the output register takes it.
// A drain runs every round-robin slice and then every FCFS run, each after a registered
// read of a ring head and in its own execute state, and ends in a flush state; a job
// left unfinished by its slice moves to the FCFS ring. Each result is held one job
// back so the final one can be flagged, and appears on the output register as the
// next job completes or at the end of the drain.
// A new request is taken only while the sequencer is idle and the output register
// is free or being emptied; when the receiver stalls, the block waits at its next
// execute or flush step with the result held stable and the rings and clock frozen.
// Reset (synchronous, active low) empties both rings, zeroes the clock and sets
// the quantum to 4. Ring contents are not cleared; no clearing pass is needed.
`default_nettype none
module two_level_rr_fcfs_scheduler #(
    parameter int PROCESS_SLOTS = rrfcfs_pkg::PROCESS_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [7:0]             i_cfg_wdata,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire rrfcfs_pkg::t_in_item   i_in_item,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output rrfcfs_pkg::t_out_item       o_out_item
);
    import rrfcfs_pkg::*;

    t_cmd    cmd;
    t_status status;

    rrfcfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_item.operation),
        .o_in_stall  (o_in_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rrfcfs_dpath #(
        .PROCESS_SLOTS (PROCESS_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
